### rtl/lbfg_pkg.sv
// Shared types and constants of the load-based frequency governor.
// No dependencies; used by lbfg_usage, lbfg_select and the top level.
package lbfg_pkg;

  localparam int TABLE_DEPTH = 32;

  localparam int NUM_CNT   = 7;
  localparam int CNT_W     = 40;
  localparam int SUM_W     = 43;
  localparam int IDLE_SLOT = 3;
  localparam int FREQ_W    = 24;
  localparam int USAGE_W   = 7;
  localparam int TIDX_W    = 5;
  localparam int NSIZE_W   = 6;
  localparam int THR_W     = 7;

  localparam int USAGE_MAX = 100;
  localparam int LOW_RST   = 25;
  localparam int HIGH_RST  = 90;
  localparam int SEL_OFFSET = 15;
  localparam int SEL_SPAN   = 70;

  // floor(x/70) == (x*SEL_RECIP) >> RECIP_SHIFT for x < 43690
  localparam int RECIP_SHIFT = 21;
  localparam int SEL_RECIP   = (2 ** RECIP_SHIFT + SEL_SPAN - 1) / SEL_SPAN;
  localparam int RECIP_W     = 15;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_TABLE_SIZE = 3'd0,
    REG_LOW_THR    = 3'd1,
    REG_HIGH_THR   = 3'd2,
    REG_STAT_EN    = 3'd3,
    REG_POLICY_EN  = 3'd4
  } reg_idx_t;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_vec_t;

  typedef struct packed {
    logic [NSIZE_W-1:0] table_size;
    logic [THR_W-1:0]   low_thr;
    logic [THR_W-1:0]   high_thr;
    logic               policy_en;
  } sel_cfg_t;

endpackage

### rtl/lbfg_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module lbfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lbfg_usage.sv
// Usage unit: counter sum, deltas against previous sample, x100 and a
// short restoring divide with saturation. Depends on lbfg_pkg.
module lbfg_usage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              sample_ok,
  input  lbfg_pkg::cnt_vec_t                counters,
  output logic                              done,
  output logic [lbfg_pkg::USAGE_W-1:0]      usage
);

  typedef enum logic [9:0] {
    U_IDLE  = 10'b0000000001,
    U_SUM   = 10'b0000000010,
    U_DELTA = 10'b0000000100,
    U_BUSY  = 10'b0000001000,
    U_MUL3  = 10'b0000010000,
    U_MUL25 = 10'b0000100000,
    U_SIGN  = 10'b0001000000,
    U_SAT   = 10'b0010000000,
    U_DIV   = 10'b0100000000,
    U_DONE  = 10'b1000000000
  } ustate_t;

  ustate_t state;

  lbfg_pkg::cnt_vec_t              cnt;
  logic                            ok;
  logic [2:0]                      k;
  logic [lbfg_pkg::SUM_W-1:0]      acc;
  logic [lbfg_pkg::SUM_W-1:0]      base_total;
  logic [lbfg_pkg::CNT_W-1:0]      base_idle;
  logic signed [43:0]              dt;
  logic signed [40:0]              di;
  logic signed [44:0]              busy;
  logic signed [46:0]              p3;
  logic signed [51:0]              num;
  logic [50:0]                     nmag;
  logic [43:0]                     dmag;
  logic [50:0]                     dsh;
  logic [50:0]                     rem;
  logic [6:0]                      qt;
  logic [2:0]                      bitn;
  logic                            trial_ok;
  logic [6:0]                      q_next;

  always_comb begin
    trial_ok = rem >= dsh;
    q_next = qt;
    if (trial_ok) begin
      q_next[bitn] = 1'b1;
    end
  end

  assign done = (state == U_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= U_IDLE;
      base_total <= '0;
      base_idle  <= '0;
    end else begin
      unique case (state)
        U_IDLE: begin
          if (start) begin
            cnt   <= counters;
            ok    <= sample_ok;
            k     <= '0;
            acc   <= '0;
            state <= U_SUM;
          end
        end
        U_SUM: begin
          acc <= acc + lbfg_pkg::SUM_W'(cnt[k]);
          k   <= k + 3'd1;
          if (k == 3'(lbfg_pkg::NUM_CNT - 1)) begin
            state <= U_DELTA;
          end
        end
        U_DELTA: begin
          dt <= signed'({1'b0, acc}) - signed'({1'b0, base_total});
          di <= signed'({1'b0, cnt[lbfg_pkg::IDLE_SLOT]}) - signed'({1'b0, base_idle});
          if (!ok) begin
            usage <= '0;
            state <= U_DONE;
          end else begin
            state <= U_BUSY;
          end
        end
        U_BUSY: begin
          if (dt == '0) begin
            usage <= '0;
            state <= U_DONE;
          end else begin
            base_total <= acc;
            base_idle  <= cnt[lbfg_pkg::IDLE_SLOT];
            busy       <= 45'(dt) - 45'(di);
            state      <= U_MUL3;
          end
        end
        U_MUL3: begin
          p3    <= (47'(busy) <<< 1) + 47'(busy);
          state <= U_MUL25;
        end
        U_MUL25: begin
          // 100*b = 4*(8*(3*b) + b)
          num   <= ((52'(p3) <<< 3) + 52'(busy)) <<< 2;
          state <= U_SIGN;
        end
        U_SIGN: begin
          if (num == '0 || num[51] != dt[43]) begin
            usage <= '0;
            state <= U_DONE;
          end else begin
            nmag  <= num[51] ? 51'(-num) : 51'(num);
            dmag  <= dt[43] ? 44'(-dt) : 44'(dt);
            state <= U_SAT;
          end
        end
        U_SAT: begin
          if (nmag >= {dmag, 7'b0}) begin
            usage <= lbfg_pkg::USAGE_W'(lbfg_pkg::USAGE_MAX);
            state <= U_DONE;
          end else begin
            rem   <= nmag;
            dsh   <= {1'b0, dmag, 6'b0};
            qt    <= '0;
            bitn  <= 3'd6;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          if (trial_ok) begin
            rem <= rem - dsh;
          end
          qt   <= q_next;
          dsh  <= dsh >> 1;
          bitn <= bitn - 3'd1;
          if (bitn == 3'd0) begin
            usage <= (q_next > 7'(lbfg_pkg::USAGE_MAX)) ?
                     lbfg_pkg::USAGE_W'(lbfg_pkg::USAGE_MAX) : q_next;
            state <= U_DONE;
          end
        end
        U_DONE: begin
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/lbfg_select.sv
// Table entry selection from usage: three-stage pipeline with a constant
// reciprocal for the divide by 70. Depends on lbfg_pkg.
module lbfg_select #(
  parameter int TABLE_DEPTH = lbfg_pkg::TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lbfg_pkg::USAGE_W-1:0]     usage,
  input  lbfg_pkg::sel_cfg_t               cfg,
  output logic                             done,
  output logic [lbfg_pkg::NSIZE_W-1:0]     idx,
  output logic                             active
);

  localparam int NW = lbfg_pkg::NSIZE_W;

  logic [2:0]              vld;

  logic [NW-1:0]           n_sat;
  logic [NW-1:0]           nm1_c;
  logic signed [7:0]       u_off;
  logic signed [NW:0]      nm1_s;

  logic [NW-1:0]           nm1_0, nm1_1;
  logic                    lo_0, hi_0, act_0, lo_1, hi_1, act_1;
  logic signed [14:0]      prod;
  logic [13:0]             mag;
  logic                    neg;
  logic [28:0]             mq;

  logic [7:0]              q;
  logic signed [9:0]       t;
  logic [NW-1:0]           idx_c;

  always_comb begin
    n_sat = (int'(cfg.table_size) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : cfg.table_size;
    nm1_c = n_sat - NW'(1);
    u_off = signed'(8'(usage)) - 8'(lbfg_pkg::SEL_OFFSET);
    nm1_s = signed'({1'b0, nm1_c});
    mag   = prod[14] ? 14'(-prod) : 14'(prod);
  end

  always_comb begin
    q = mq[28:lbfg_pkg::RECIP_SHIFT];
    t = signed'(10'(nm1_1)) + (neg ? signed'(10'(q)) : -signed'(10'(q)));
    if (lo_1) begin
      idx_c = nm1_1;
    end else if (hi_1) begin
      idx_c = '0;
    end else if (t < 0) begin
      idx_c = '0;
    end else if (t > signed'(10'(nm1_1))) begin
      idx_c = nm1_1;
    end else begin
      idx_c = t[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nm1_0 <= nm1_c;
      lo_0  <= usage < cfg.low_thr;
      hi_0  <= usage > cfg.high_thr;
      act_0 <= cfg.policy_en && (n_sat != '0);
      prod  <= u_off * nm1_s;
    end
    if (vld[0]) begin
      nm1_1 <= nm1_0;
      lo_1  <= lo_0;
      hi_1  <= hi_0;
      act_1 <= act_0;
      neg   <= prod[14];
      mq    <= 29'(mag) * 29'(lbfg_pkg::SEL_RECIP);
    end
    if (vld[1]) begin
      idx    <= idx_c;
      active <= act_1;
    end
  end

  assign done = vld[2];

endmodule

### rtl/load_based_frequency_governor.sv
// Load-based frequency governor: one result per load sample, none per
// table write. A sample goes through the counter sum, the usage divide
// path, selection, the table read and the load of the output register;
// the usage path ends early when usage settles early. A table write is
// done on acceptance. Input is taken again once the output register is
// loaded, so one sample is in flight at a time. Synchronous reset, no clearing pass.
module load_based_frequency_governor #(
  parameter int TABLE_DEPTH = lbfg_pkg::TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lbfg_pkg::APB_AW-1:0]       paddr,
  input  logic [lbfg_pkg::APB_DW-1:0]       pwdata,
  output logic [lbfg_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [4:0]                        entry_index,
  input  logic [lbfg_pkg::FREQ_W-1:0]       entry_value,
  input  logic [lbfg_pkg::CNT_W-1:0]        user_ticks,
  input  logic [lbfg_pkg::CNT_W-1:0]        nice_ticks,
  input  logic [lbfg_pkg::CNT_W-1:0]        system_ticks,
  input  logic [lbfg_pkg::CNT_W-1:0]        idle_ticks,
  input  logic [lbfg_pkg::CNT_W-1:0]        iowait_ticks,
  input  logic [lbfg_pkg::CNT_W-1:0]        irq_ticks,
  input  logic [lbfg_pkg::CNT_W-1:0]        softirq_ticks,
  input  logic                              sample_valid,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lbfg_pkg::USAGE_W-1:0]      usage_percent,
  output logic [lbfg_pkg::TIDX_W-1:0]       target_index,
  output logic [lbfg_pkg::FREQ_W-1:0]       freq_khz,
  output logic                              set_request
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_USAGE = 4'b0010,
    T_SEL   = 4'b0100,
    T_OUT   = 4'b1000
  } tstate_t;

  tstate_t state;

  logic [lbfg_pkg::NSIZE_W-1:0] table_size;
  logic [lbfg_pkg::THR_W-1:0]   low_thr;
  logic [lbfg_pkg::THR_W-1:0]   high_thr;
  logic                         stat_en;
  logic                         policy_en;

  logic                         cfg_wr;
  lbfg_pkg::reg_idx_t           reg_sel;

  logic                         accept;
  logic                         is_sample;
  logic                         tbl_we;
  logic                         rd_en;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;
  logic [lbfg_pkg::FREQ_W-1:0]  rdata;

  lbfg_pkg::cnt_vec_t           counters;
  lbfg_pkg::sel_cfg_t           sel_cfg;

  logic                         u_done;
  logic [lbfg_pkg::USAGE_W-1:0] u_usage;
  logic                         sel_done;
  logic [lbfg_pkg::NSIZE_W-1:0] sel_idx;
  logic                         sel_act;

  logic [lbfg_pkg::FREQ_W-1:0]  last_freq;
  logic                         last_valid;
  logic                         out_load;
  logic [lbfg_pkg::FREQ_W-1:0]  freq_c;
  logic                         set_c;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = lbfg_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
      low_thr    <= lbfg_pkg::THR_W'(lbfg_pkg::LOW_RST);
      high_thr   <= lbfg_pkg::THR_W'(lbfg_pkg::HIGH_RST);
      stat_en    <= 1'b1;
      policy_en  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lbfg_pkg::REG_TABLE_SIZE: table_size <= pwdata[lbfg_pkg::NSIZE_W-1:0];
        lbfg_pkg::REG_LOW_THR:    low_thr    <= pwdata[lbfg_pkg::THR_W-1:0];
        lbfg_pkg::REG_HIGH_THR:   high_thr   <= pwdata[lbfg_pkg::THR_W-1:0];
        lbfg_pkg::REG_STAT_EN:    stat_en    <= pwdata[0];
        lbfg_pkg::REG_POLICY_EN:  policy_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lbfg_pkg::REG_TABLE_SIZE: prdata = lbfg_pkg::APB_DW'(table_size);
      lbfg_pkg::REG_LOW_THR:    prdata = lbfg_pkg::APB_DW'(low_thr);
      lbfg_pkg::REG_HIGH_THR:   prdata = lbfg_pkg::APB_DW'(high_thr);
      lbfg_pkg::REG_STAT_EN:    prdata = lbfg_pkg::APB_DW'(stat_en);
      lbfg_pkg::REG_POLICY_EN:  prdata = lbfg_pkg::APB_DW'(policy_en);
      default:                  prdata = '0;
    endcase
  end

  // input transactions
  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_sample = (lbfg_pkg::opcode_t'(opcode) == lbfg_pkg::OP_SAMPLE);
  assign tbl_we    = accept && !is_sample && (int'(entry_index) < TABLE_DEPTH);
  assign waddr     = AW'(entry_index);
  assign rd_en     = (state == T_SEL) && sel_done;
  assign raddr     = AW'(sel_idx);

  assign counters = {softirq_ticks, irq_ticks, iowait_ticks, idle_ticks,
                     system_ticks, nice_ticks, user_ticks};

  assign sel_cfg = '{table_size: table_size, low_thr: low_thr,
                     high_thr: high_thr, policy_en: policy_en};

  lbfg_ram #(
    .WIDTH (lbfg_pkg::FREQ_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (entry_value),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  lbfg_usage u_usage_unit (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && is_sample),
    .sample_ok (sample_valid && stat_en),
    .counters  (counters),
    .done      (u_done),
    .usage     (u_usage)
  );

  lbfg_select #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_select (
    .clk    (clk),
    .rst    (rst),
    .start  (u_done),
    .usage  (u_usage),
    .cfg    (sel_cfg),
    .done   (sel_done),
    .idx    (sel_idx),
    .active (sel_act)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE:  if (accept && is_sample) state <= T_USAGE;
        T_USAGE: if (u_done) state <= T_SEL;
        T_SEL:   if (sel_done) state <= T_OUT;
        T_OUT:   if (out_load) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  // output register
  assign out_load = (state == T_OUT) && (!out_valid || out_ready);
  assign freq_c   = sel_act ? rdata : '0;
  assign set_c    = sel_act && (!last_valid || rdata != last_freq);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_valid <= 1'b0;
      last_freq  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load && set_c) begin
        last_valid <= 1'b1;
        last_freq  <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      usage_percent <= u_usage;
      target_index  <= sel_act ? sel_idx[lbfg_pkg::TIDX_W-1:0] : '0;
      freq_khz      <= freq_c;
      set_request   <= set_c;
    end
  end

  a_usage_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    u_done |-> state == T_USAGE)
    else $error("usage unit finished outside its wait state");

  a_sel_latency: assert property (@(posedge clk) disable iff (rst)
    sel_done |-> $past(u_done, 3))
    else $error("selection result without matching usage result");

  a_set_marks_applied: assert property (@(posedge clk) disable iff (rst)
    out_valid && set_request |-> last_valid)
    else $error("set request delivered without an applied frequency");

endmodule
